>>> rtl/lj_pair_force_2d_unit_macros.svh
// ---------------------------------------------------------------------------
// lj_pair_force_2d_unit_macros.svh
// Assertion macros used by the pair force unit port checker.
// ---------------------------------------------------------------------------
`ifndef LJ_PAIR_FORCE_2D_UNIT_MACROS_SVH
`define LJ_PAIR_FORCE_2D_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LJ2_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LJ2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// signal unchanged in the cycle after the condition, disabled in reset
`define LJ2_ASSERT_HOLD(lbl, clk, rst_n, ante, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
        else $error(msg);

`endif

>>> rtl/lj2_pkg.sv
// ---------------------------------------------------------------------------
// lj2_pkg
// Shared constants and types of the Lennard-Jones pair force unit.
// ---------------------------------------------------------------------------
`default_nettype none

package lj2_pkg;

    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned TAG_BITS_DEF = 12;
    localparam int unsigned CFG_W        = 32;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned OUT_W        = 48;
    localparam int unsigned MUL_W        = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_LENGTH     = 3'd0,
        CFG_INV_BOX_LENGTH = 3'd1,
        CFG_CUT_RADIUS_SQ  = 3'd2,
        CFG_MIN_RADIUS_SQ  = 3'd3,
        CFG_SIGMA_SQ       = 3'd4,
        CFG_FOUR_EPS       = 3'd5,
        CFG_TWENTYFOUR_EPS = 3'd6,
        CFG_FORCE_LIMIT    = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_BOX_LENGTH     = 32'd2228224;
    localparam logic [CFG_W-1:0] RST_INV_BOX_LENGTH = 32'd126322568;
    localparam logic [CFG_W-1:0] RST_CUT_RADIUS_SQ  = 32'd4734976;
    localparam logic [CFG_W-1:0] RST_MIN_RADIUS_SQ  = 32'd320084;
    localparam logic [CFG_W-1:0] RST_SIGMA_SQ       = 32'd757596;
    localparam logic [CFG_W-1:0] RST_FOUR_EPS       = 32'd26048022;
    localparam logic [CFG_W-1:0] RST_TWENTYFOUR_EPS = 32'd156288133;
    localparam logic [CFG_W-1:0] RST_FORCE_LIMIT    = 32'd524288000;

    // saturation caps
    localparam logic [MUL_W-1:0] CAP62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [MUL_W-1:0] NEG47 = 64'h0000_8000_0000_0000;
    localparam logic [MUL_W-1:0] POS47 = 64'h0000_7FFF_FFFF_FFFF;

endpackage

`default_nettype wire

>>> rtl/lj2_mul.sv
// ---------------------------------------------------------------------------
// lj2_mul
// 64x64 unsigned multiplier, three register stages, 32-bit partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module lj2_mul
    import lj2_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [MUL_W-1:0]     i_a,
    input  wire logic [MUL_W-1:0]     i_b,
    output logic      [2*MUL_W-1:0]   o_p
);

    localparam int unsigned HW = MUL_W / 2;

    logic [MUL_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [MUL_W-1:0] r_lo, r_hi;
    logic [MUL_W:0]   r_mid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: partial products
            r_p00 <= i_a[HW-1:0]     * i_b[HW-1:0];
            r_p01 <= i_a[HW-1:0]     * i_b[MUL_W-1:HW];
            r_p10 <= i_a[MUL_W-1:HW] * i_b[HW-1:0];
            r_p11 <= i_a[MUL_W-1:HW] * i_b[MUL_W-1:HW];
            // stage 2: cross terms
            r_lo  <= r_p00;
            r_hi  <= r_p11;
            r_mid <= {1'b0, r_p01} + {1'b0, r_p10};
            // stage 3: final sum
            o_p   <= {r_hi, r_lo} + ({{(MUL_W-1){1'b0}}, r_mid} << HW);
        end
    end

endmodule

`default_nettype wire

>>> rtl/lj_pair_force_2d_unit.sv
// ---------------------------------------------------------------------------
// lj_pair_force_2d_unit
// Lennard-Jones pair force and energy, 2-D, nearest periodic image, cutoff.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ---------------------------
//  pair in   input      i_in_valid / o_in_stall    delta_x, delta_y, two tags
//  result    output     o_out_valid / i_out_stall  force_x/y, energy, flag, tags
//  config    input      i_cfg_we (no handshake)    i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle sustained when nothing stalls.
//  Depth is set by the two 48-step restoring dividers running side by side
//  (one quotient bit per stage) plus eight 3-stage multipliers in series.
//  Reset clears valid bits, the skid flag and restores register defaults.
//  A stalled result freezes the whole pipe; a one-beat input skid takes the
//  beat offered in that cycle, so o_in_stall is a plain register.
// ---------------------------------------------------------------------------
`default_nettype none

module lj_pair_force_2d_unit
    import lj2_pkg::*;
#(
    parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_wdata,
    // pair input
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [31:0]      i_delta_x,
    input  wire logic signed [31:0]      i_delta_y,
    input  wire logic [TAG_BITS-1:0]     i_first_tag,
    input  wire logic [TAG_BITS-1:0]     i_second_tag,
    // result output
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [OUT_W-1:0]      o_force_x,
    output logic signed [OUT_W-1:0]      o_force_y,
    output logic signed [OUT_W-1:0]      o_energy_term,
    output logic                         o_in_range,
    output logic [TAG_BITS-1:0]          o_first_tag_out,
    output logic [TAG_BITS-1:0]          o_second_tag_out
);

    // widths
    localparam int unsigned KW  = 32 - FRAC_BITS;      // image count bits
    localparam int unsigned KLW = KW + 32;             // k*L bits
    localparam int unsigned TW  = KLW + 2;             // folded diff, signed
    localparam int unsigned R2W = MUL_W - FRAC_BITS;   // r^2 bits
    localparam int unsigned QW  = 32 + FRAC_BITS;      // quotient bits

    // stage map
    localparam int unsigned ST_R2F = 15;
    localparam int unsigned ST_Q   = ST_R2F + QW;
    localparam int unsigned ST_QQ  = ST_Q + 4;
    localparam int unsigned ST_Q3  = ST_QQ + 4;
    localparam int unsigned ST_Q6  = ST_Q3 + 4;
    localparam int unsigned ST_G   = ST_Q6 + 1;
    localparam int unsigned ST_F   = ST_G + 4;
    localparam int unsigned ST_OUT = ST_F + 4;

    localparam logic [MUL_W-1:0] RND = MUL_W'(1) << (FRAC_BITS + 31);

    function automatic logic [MUL_W-1:0] f_cap(input logic [2*MUL_W-1:0] p,
                                               input logic [MUL_W-1:0] cap);
        logic [2*MUL_W-1:0] t;
        t = p >> FRAC_BITS;
        return (t > {{MUL_W{1'b0}}, cap}) ? cap : t[MUL_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] f_sat48(input logic neg,
                                                 input logic [MUL_W-1:0] mag);
        logic [MUL_W-1:0] lim;
        logic [MUL_W-1:0] m;
        lim = neg ? NEG47 : POS47;
        m   = (mag > lim) ? lim : mag;
        return neg ? OUT_W'(MUL_W'(0) - m) : m[OUT_W-1:0];
    endfunction

    // one restoring-divide step: {quotient bit, new remainder}
    function automatic logic [32:0] f_div_step(input logic [31:0] rem,
                                               input logic b,
                                               input logic [31:0] dv);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, b};
        d = {1'b0, dv};
        if (t >= d) begin
            return {1'b1, 32'(t - d)};
        end else begin
            return {1'b0, t[31:0]};
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_box, r_inv, r_cut, r_min, r_sig, r_e4, r_e24, r_flim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box  <= RST_BOX_LENGTH;
            r_inv  <= RST_INV_BOX_LENGTH;
            r_cut  <= RST_CUT_RADIUS_SQ;
            r_min  <= RST_MIN_RADIUS_SQ;
            r_sig  <= RST_SIGMA_SQ;
            r_e4   <= RST_FOUR_EPS;
            r_e24  <= RST_TWENTYFOUR_EPS;
            r_flim <= RST_FORCE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_LENGTH:     r_box  <= i_cfg_wdata;
                CFG_INV_BOX_LENGTH: r_inv  <= i_cfg_wdata;
                CFG_CUT_RADIUS_SQ:  r_cut  <= i_cfg_wdata;
                CFG_MIN_RADIUS_SQ:  r_min  <= i_cfg_wdata;
                CFG_SIGMA_SQ:       r_sig  <= i_cfg_wdata;
                CFG_FOUR_EPS:       r_e4   <= i_cfg_wdata;
                CFG_TWENTYFOUR_EPS: r_e24  <= i_cfg_wdata;
                CFG_FORCE_LIMIT:    r_flim <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe enable and input skid
    // ------------------------------------------------------------------
    logic                 en;
    logic                 in_acc;
    logic [0:ST_OUT]      r_v;
    logic                 r_skid_full;
    logic signed [31:0]   r_sk_dx, r_sk_dy;
    logic [TAG_BITS-1:0]  r_sk_t1, r_sk_t2;
    logic                 w_s_v;
    logic signed [31:0]   w_s_dx, w_s_dy;
    logic [TAG_BITS-1:0]  w_s_t1, w_s_t2;

    // whole pipe moves unless the result register holds an unclaimed beat
    assign en         = !r_v[ST_OUT] || !i_out_stall;
    assign o_in_stall = r_skid_full;
    assign in_acc     = i_in_valid && !r_skid_full;

    assign w_s_v  = r_skid_full || in_acc;
    assign w_s_dx = r_skid_full ? r_sk_dx : i_delta_x;
    assign w_s_dy = r_skid_full ? r_sk_dy : i_delta_y;
    assign w_s_t1 = r_skid_full ? r_sk_t1 : i_first_tag;
    assign w_s_t2 = r_skid_full ? r_sk_t2 : i_second_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (en) begin
            r_skid_full <= 1'b0;
        end else if (in_acc) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_acc) begin
            r_sk_dx <= i_delta_x;
            r_sk_dy <= i_delta_y;
            r_sk_t1 <= i_first_tag;
            r_sk_t2 <= i_second_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {w_s_v, r_v[0:ST_OUT-1]};
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [31:0]  r0_dx, r0_dy;
    logic [TAG_BITS-1:0] r_t1_d [0:ST_OUT-1];
    logic [TAG_BITS-1:0] r_t2_d [0:ST_OUT-1];
    logic signed [31:0]  r_dx_d [1:8];
    logic signed [31:0]  r_dy_d [1:8];
    logic [31:0]         r1_magx, r1_magy;
    logic [KW-1:0]       r5_kx, r5_ky;
    logic signed [31:0]  r9_rx, r9_ry;
    logic [31:0]         r10_mx, r10_my;
    logic                r10_sx, r10_sy;
    logic [31:0]         r_mx_d [11:ST_F];
    logic [31:0]         r_my_d [11:ST_F];
    logic                r_sx_d [11:ST_OUT-1];
    logic                r_sy_d [11:ST_OUT-1];
    logic [R2W-1:0]      r14_r2;
    logic                r15_inr;
    logic [31:0]         r15_r2f;
    logic                r_inr_d [ST_R2F+1:ST_OUT-1];
    logic [31:0]         r_div  [0:QW-1];
    logic [31:0]         r_remq [0:QW-1];
    logic [31:0]         r_rema [0:QW-1];
    logic [QW-1:0]       r_quoq [0:QW-1];
    logic [QW-1:0]       r_quoa [0:QW-1];
    logic [QW-1:0]       r_q_d  [ST_Q+1:ST_QQ];
    logic [QW-1:0]       r_a_d  [ST_Q+1:ST_G];
    logic [MUL_W-1:0]    r67_qq, r71_q3, r75_q6;
    logic [MUL_W-1:0]    r_q3_d [ST_Q3+1:ST_Q6];
    logic                r76_eneg, r76_gneg;
    logic [MUL_W-1:0]    r76_dmag, r76_gmag;
    logic                r_eneg_d [ST_G+1:ST_OUT-1];
    logic                r_gneg_d [ST_G+1:ST_OUT-1];
    logic [OUT_W-1:0]    r80_e;
    logic [31:0]         r80_f;
    logic [OUT_W-1:0]    r_e_d [ST_F+1:ST_OUT-1];

    // multiplier products
    logic [2*MUL_W-1:0] w_pa_x, w_pa_y, w_pb_x, w_pb_y, w_pc_x, w_pc_y;
    logic [2*MUL_W-1:0] w_pd, w_pe, w_pf, w_pg, w_ph, w_pi_x, w_pi_y;

    // ------------------------------------------------------------------
    // stage combinational terms
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]     w_rnd_x, w_rnd_y;
    logic signed [TW-1:0] w_tx, w_ty;
    logic [31:0]          w_rx, w_ry;
    logic [MUL_W-1:0]     w_r2sum;
    logic [31:0]          w_r2sel;
    logic [MUL_W-1:0]     w_2q6;
    logic [QW-1:0]        w_numq, w_numa;
    logic [32:0]          w_stq [0:QW-1];
    logic [32:0]          w_sta [0:QW-1];
    logic [MUL_W-1:0]     w_fxm, w_fym;

    // nearest image: k = round(|d| / L), half away from zero
    assign w_rnd_x = w_pa_x[MUL_W-1:0] + RND;
    assign w_rnd_y = w_pa_y[MUL_W-1:0] + RND;

    // d -/+ k*L, then clip to signed 32
    always_comb begin
        logic signed [TW-1:0] dx_e, dy_e, klx, kly;
        dx_e = {{(TW-32){r_dx_d[8][31]}}, r_dx_d[8]};
        dy_e = {{(TW-32){r_dy_d[8][31]}}, r_dy_d[8]};
        klx  = {2'b00, w_pb_x[KLW-1:0]};
        kly  = {2'b00, w_pb_y[KLW-1:0]};
        w_tx = r_dx_d[8][31] ? dx_e + klx : dx_e - klx;
        w_ty = r_dy_d[8][31] ? dy_e + kly : dy_e - kly;
    end

    always_comb begin
        if (w_tx[TW-1] && !(&w_tx[TW-1:31])) begin
            w_rx = 32'h8000_0000;
        end else if (!w_tx[TW-1] && (|w_tx[TW-1:31])) begin
            w_rx = 32'h7FFF_FFFF;
        end else begin
            w_rx = w_tx[31:0];
        end
        if (w_ty[TW-1] && !(&w_ty[TW-1:31])) begin
            w_ry = 32'h8000_0000;
        end else if (!w_ty[TW-1] && (|w_ty[TW-1:31])) begin
            w_ry = 32'h7FFF_FFFF;
        end else begin
            w_ry = w_ty[31:0];
        end
    end

    assign w_r2sum = w_pc_x[MUL_W-1:0] + w_pc_y[MUL_W-1:0];
    // floored distance; truncation is harmless since out-of-range beats
    // never use it
    assign w_r2sel = (r14_r2 < {{(R2W-32){1'b0}}, r_min}) ? r_min : r14_r2[31:0];

    // dividends: sigma^2 and 24 eps, both scaled by 2^F
    assign w_numq = {r_sig, {FRAC_BITS{1'b0}}};
    assign w_numa = {r_e24, {FRAC_BITS{1'b0}}};

    for (genvar j = 0; j < QW; j++) begin : g_div
        if (j == 0) begin : g_first
            assign w_stq[j] = f_div_step('0, w_numq[QW-1-j], r15_r2f);
            assign w_sta[j] = f_div_step('0, w_numa[QW-1-j], r15_r2f);
        end else begin : g_rest
            assign w_stq[j] = f_div_step(r_remq[j-1], w_numq[QW-1-j], r_div[j-1]);
            assign w_sta[j] = f_div_step(r_rema[j-1], w_numa[QW-1-j], r_div[j-1]);
        end
    end

    assign w_2q6 = {r75_q6[MUL_W-2:0], 1'b0};
    assign w_fxm = w_pi_x[MUL_W-1+FRAC_BITS:FRAC_BITS];
    assign w_fym = w_pi_y[MUL_W-1+FRAC_BITS:FRAC_BITS];

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 0: entry
            r0_dx     <= w_s_dx;
            r0_dy     <= w_s_dy;
            r_t1_d[0] <= w_s_t1;
            r_t2_d[0] <= w_s_t2;
            for (int i = 1; i < ST_OUT; i++) begin
                r_t1_d[i] <= r_t1_d[i-1];
                r_t2_d[i] <= r_t2_d[i-1];
            end

            // stage 1: magnitudes for the image count
            r1_magx   <= r0_dx[31] ? 32'(0 - r0_dx) : r0_dx;
            r1_magy   <= r0_dy[31] ? 32'(0 - r0_dy) : r0_dy;
            r_dx_d[1] <= r0_dx;
            r_dy_d[1] <= r0_dy;
            for (int i = 2; i <= 8; i++) begin
                r_dx_d[i] <= r_dx_d[i-1];
                r_dy_d[i] <= r_dy_d[i-1];
            end

            // stage 5: rounded image count
            r5_kx <= w_rnd_x[MUL_W-1 -: KW];
            r5_ky <= w_rnd_y[MUL_W-1 -: KW];

            // stage 9: folded difference
            r9_rx <= w_rx;
            r9_ry <= w_ry;

            // stage 10: |r| and sign
            r10_mx <= r9_rx[31] ? 32'(0 - r9_rx) : r9_rx;
            r10_my <= r9_ry[31] ? 32'(0 - r9_ry) : r9_ry;
            r10_sx <= r9_rx[31];
            r10_sy <= r9_ry[31];
            r_mx_d[11] <= r10_mx;
            r_my_d[11] <= r10_my;
            for (int i = 12; i <= ST_F; i++) begin
                r_mx_d[i] <= r_mx_d[i-1];
                r_my_d[i] <= r_my_d[i-1];
            end
            r_sx_d[11] <= r10_sx;
            r_sy_d[11] <= r10_sy;
            for (int i = 12; i < ST_OUT; i++) begin
                r_sx_d[i] <= r_sx_d[i-1];
                r_sy_d[i] <= r_sy_d[i-1];
            end

            // stage 14: r^2
            r14_r2 <= w_r2sum[MUL_W-1:FRAC_BITS];

            // stage 15: cutoff test and floored divisor
            r15_inr <= r14_r2 < {{(R2W-32){1'b0}}, r_cut};
            r15_r2f <= (w_r2sel == '0) ? 32'd1 : w_r2sel;
            r_inr_d[ST_R2F+1] <= r15_inr;
            for (int i = ST_R2F + 2; i < ST_OUT; i++) begin
                r_inr_d[i] <= r_inr_d[i-1];
            end

            // divider stages: one quotient bit per stage
            r_div[0]  <= r15_r2f;
            r_remq[0] <= w_stq[0][31:0];
            r_rema[0] <= w_sta[0][31:0];
            r_quoq[0] <= {{(QW-1){1'b0}}, w_stq[0][32]};
            r_quoa[0] <= {{(QW-1){1'b0}}, w_sta[0][32]};
            for (int j = 1; j < QW; j++) begin
                r_div[j]  <= r_div[j-1];
                r_remq[j] <= w_stq[j][31:0];
                r_rema[j] <= w_sta[j][31:0];
                r_quoq[j] <= {r_quoq[j-1][QW-2:0], w_stq[j][32]};
                r_quoa[j] <= {r_quoa[j-1][QW-2:0], w_sta[j][32]};
            end

            r_q_d[ST_Q+1] <= r_quoq[QW-1];
            for (int i = ST_Q + 2; i <= ST_QQ; i++) begin
                r_q_d[i] <= r_q_d[i-1];
            end
            r_a_d[ST_Q+1] <= r_quoa[QW-1];
            for (int i = ST_Q + 2; i <= ST_G; i++) begin
                r_a_d[i] <= r_a_d[i-1];
            end

            // q^2, q^3, q^6 with saturation
            r67_qq <= f_cap(w_pd, CAP62);
            r71_q3 <= f_cap(w_pe, CAP62);
            r75_q6 <= f_cap(w_pf, CAP62);
            r_q3_d[ST_Q3+1] <= r71_q3;
            for (int i = ST_Q3 + 2; i <= ST_Q6; i++) begin
                r_q3_d[i] <= r_q3_d[i-1];
            end

            // stage 76: energy and force shape terms, sign and magnitude
            r76_eneg <= r75_q6 < r_q3_d[ST_Q6];
            r76_dmag <= (r75_q6 < r_q3_d[ST_Q6]) ? r_q3_d[ST_Q6] - r75_q6
                                                 : r75_q6 - r_q3_d[ST_Q6];
            r76_gneg <= w_2q6 < r_q3_d[ST_Q6];
            r76_gmag <= (w_2q6 < r_q3_d[ST_Q6]) ? r_q3_d[ST_Q6] - w_2q6
                                                : w_2q6 - r_q3_d[ST_Q6];
            r_eneg_d[ST_G+1] <= r76_eneg;
            r_gneg_d[ST_G+1] <= r76_gneg;
            for (int i = ST_G + 2; i < ST_OUT; i++) begin
                r_eneg_d[i] <= r_eneg_d[i-1];
                r_gneg_d[i] <= r_gneg_d[i-1];
            end

            // stage 80: energy magnitude and clamped force factor
            r80_e <= OUT_W'(f_cap(w_pg, NEG47));
            r80_f <= 32'(f_cap(w_ph, {{(MUL_W-CFG_W){1'b0}}, r_flim}));
            r_e_d[ST_F+1] <= r80_e;
            for (int i = ST_F + 2; i < ST_OUT; i++) begin
                r_e_d[i] <= r_e_d[i-1];
            end

            // result register
            if (r_inr_d[ST_OUT-1]) begin
                o_force_x <= f_sat48(r_gneg_d[ST_OUT-1] != r_sx_d[ST_OUT-1], w_fxm);
                o_force_y <= f_sat48(r_gneg_d[ST_OUT-1] != r_sy_d[ST_OUT-1], w_fym);
                o_energy_term <= f_sat48(r_eneg_d[ST_OUT-1],
                                         {{(MUL_W-OUT_W){1'b0}}, r_e_d[ST_OUT-1]});
            end else begin
                o_force_x     <= '0;
                o_force_y     <= '0;
                o_energy_term <= '0;
            end
            o_in_range       <= r_inr_d[ST_OUT-1];
            o_first_tag_out  <= r_t1_d[ST_OUT-1];
            o_second_tag_out <= r_t2_d[ST_OUT-1];
        end
    end

    assign o_out_valid = r_v[ST_OUT];

    // ------------------------------------------------------------------
    // multipliers
    // ------------------------------------------------------------------
    lj2_mul u_mul_kx (.i_clk, .i_en(en),
        .i_a({32'd0, r1_magx}), .i_b({32'd0, r_inv}), .o_p(w_pa_x));
    lj2_mul u_mul_ky (.i_clk, .i_en(en),
        .i_a({32'd0, r1_magy}), .i_b({32'd0, r_inv}), .o_p(w_pa_y));
    lj2_mul u_mul_lx (.i_clk, .i_en(en),
        .i_a({{(MUL_W-KW){1'b0}}, r5_kx}), .i_b({32'd0, r_box}), .o_p(w_pb_x));
    lj2_mul u_mul_ly (.i_clk, .i_en(en),
        .i_a({{(MUL_W-KW){1'b0}}, r5_ky}), .i_b({32'd0, r_box}), .o_p(w_pb_y));
    lj2_mul u_mul_sx (.i_clk, .i_en(en),
        .i_a({32'd0, r10_mx}), .i_b({32'd0, r10_mx}), .o_p(w_pc_x));
    lj2_mul u_mul_sy (.i_clk, .i_en(en),
        .i_a({32'd0, r10_my}), .i_b({32'd0, r10_my}), .o_p(w_pc_y));
    lj2_mul u_mul_qq (.i_clk, .i_en(en),
        .i_a({{(MUL_W-QW){1'b0}}, r_quoq[QW-1]}),
        .i_b({{(MUL_W-QW){1'b0}}, r_quoq[QW-1]}), .o_p(w_pd));
    lj2_mul u_mul_q3 (.i_clk, .i_en(en),
        .i_a(r67_qq), .i_b({{(MUL_W-QW){1'b0}}, r_q_d[ST_QQ]}), .o_p(w_pe));
    lj2_mul u_mul_q6 (.i_clk, .i_en(en),
        .i_a(r71_q3), .i_b(r71_q3), .o_p(w_pf));
    lj2_mul u_mul_en (.i_clk, .i_en(en),
        .i_a(r76_dmag), .i_b({32'd0, r_e4}), .o_p(w_pg));
    lj2_mul u_mul_ff (.i_clk, .i_en(en),
        .i_a({{(MUL_W-QW){1'b0}}, r_a_d[ST_G]}), .i_b(r76_gmag), .o_p(w_ph));
    lj2_mul u_mul_fx (.i_clk, .i_en(en),
        .i_a({32'd0, r80_f}), .i_b({32'd0, r_mx_d[ST_F]}), .o_p(w_pi_x));
    lj2_mul u_mul_fy (.i_clk, .i_en(en),
        .i_a({32'd0, r80_f}), .i_b({32'd0, r_my_d[ST_F]}), .o_p(w_pi_y));

endmodule

`default_nettype wire

>>> rtl/lj2_chk.sv
// ---------------------------------------------------------------------------
// lj2_chk
// Port-level checks of the pair force unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lj_pair_force_2d_unit_macros.svh"

module lj2_chk
    import lj2_pkg::*;
#(
    parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic signed [31:0]      i_delta_x,
    input wire logic signed [31:0]      i_delta_y,
    input wire logic [TAG_BITS-1:0]     i_first_tag,
    input wire logic [TAG_BITS-1:0]     i_second_tag,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic signed [OUT_W-1:0] o_force_x,
    input wire logic signed [OUT_W-1:0] o_force_y,
    input wire logic signed [OUT_W-1:0] o_energy_term,
    input wire logic                    o_in_range,
    input wire logic [TAG_BITS-1:0]     o_first_tag_out,
    input wire logic [TAG_BITS-1:0]     o_second_tag_out
);

    logic                          w_out_wait, w_in_wait, w_miss, w_zero;
    logic [3*OUT_W+2*TAG_BITS+1:0] w_out_bus;
    logic [64+2*TAG_BITS:0]        w_in_bus;

    assign w_out_wait = o_out_valid && i_out_stall;
    assign w_in_wait  = i_in_valid && o_in_stall;
    assign w_miss     = o_out_valid && !o_in_range;
    assign w_zero     = (o_force_x == '0) && (o_force_y == '0) && (o_energy_term == '0);
    assign w_out_bus  = {o_out_valid, o_force_x, o_force_y, o_energy_term, o_in_range,
                         o_first_tag_out, o_second_tag_out};
    assign w_in_bus   = {i_in_valid, i_delta_x, i_delta_y, i_first_tag, i_second_tag};

    // a stalled result beat stays put
    `LJ2_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, w_out_wait, w_out_bus, "stalled result moved")

    // a stalled pair beat stays put
    `LJ2_ASSERT_HOLD(a_in_hold, i_clk, i_rst_n, w_in_wait, w_in_bus, "stalled pair moved")

    // skid empties in any cycle the pipe moves
    `LJ2_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, !w_out_wait, !o_in_stall, "skid not drained")

    // out of cutoff gives zero force and energy
    `LJ2_ASSERT_NOW(a_out_zero, i_clk, i_rst_n, w_miss, w_zero, "nonzero result outside cutoff")

endmodule

bind lj_pair_force_2d_unit lj2_chk #(.TAG_BITS(TAG_BITS)) u_lj2_chk (.*);

`default_nettype wire

>>> tb/sv/lj_pair_force_2d_unit_chk.sv
// ---------------------------------------------------------------------------
// lj_pair_force_2d_unit_chk
// Watches the pair and result channels, predicts each result and compares.
// ---------------------------------------------------------------------------
module lj_pair_force_2d_unit_chk
    import lj2_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [31:0]      i_delta_x,
    input  logic signed [31:0]      i_delta_y,
    input  logic [11:0]             i_first_tag,
    input  logic [11:0]             i_second_tag,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [47:0]      i_force_x,
    input  logic signed [47:0]      i_force_y,
    input  logic signed [47:0]      i_energy_term,
    input  logic                    i_in_range,
    input  logic [11:0]             i_first_tag_out,
    input  logic [11:0]             i_second_tag_out,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_in_beats,
    output int                      o_out_beats,
    output int                      o_hit_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] en;
        logic        hit;
        logic [11:0] t1;
        logic [11:0] t2;
    } t_force_res;

    logic [31:0] box_l, inv_box, cut_sq, min_sq, sig_sq, eps4, eps24, f_lim;
    t_force_res  force_q[$];

    // floor(a*b >> F), saturated at cap
    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
        return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function automatic logic [47:0] sat48(logic neg, logic [63:0] mag);
        logic [63:0] lim;
        lim = neg ? NEG47 : POS47;
        if (mag > lim) mag = lim;
        return neg ? 48'(-mag) : mag[47:0];
    endfunction

    function automatic longint fold_image(longint d);
        logic [63:0] mag, k;
        longint kl, r;
        mag = (d < 0) ? -d : d;
        k = (mag * inv_box + (64'd1 << (FRAC_BITS + 31))) >> (FRAC_BITS + 32);
        kl = longint'(k * box_l);
        r = (d < 0) ? d + kl : d - kl;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic t_force_res predict_force(logic signed [31:0] dx, logic signed [31:0] dy,
                                                 logic [11:0] t1, logic [11:0] t2);
        t_force_res  res;
        longint      rx, ry;
        logic [63:0] mx, my, r2, r2f, q, q3, q6, dmag, gmag, a, f, e;
        logic        eneg, gneg;
        rx = fold_image(longint'(dx));
        ry = fold_image(longint'(dy));
        mx = (rx < 0) ? -rx : rx;
        my = (ry < 0) ? -ry : ry;
        r2 = (mx * mx + my * my) >> FRAC_BITS;
        res = '0;
        res.t1 = t1;
        res.t2 = t2;
        if (r2 < cut_sq) begin
            r2f = (r2 < min_sq) ? min_sq : r2;
            if (r2f == 0) r2f = 1;
            q = ({32'd0, sig_sq} << FRAC_BITS) / r2f;
            q3 = mul_sat(mul_sat(q, q, CAP62), q, CAP62);
            q6 = mul_sat(q3, q3, CAP62);
            eneg = q6 < q3;
            dmag = eneg ? q3 - q6 : q6 - q3;
            e = mul_sat(dmag, eps4, NEG47);
            gneg = 2 * q6 < q3;
            gmag = gneg ? q3 - 2 * q6 : 2 * q6 - q3;
            a = ({32'd0, eps24} << FRAC_BITS) / r2f;
            f = mul_sat(a, gmag, f_lim);
            res.fx = sat48(gneg != (rx < 0), (f * mx) >> FRAC_BITS);
            res.fy = sat48(gneg != (ry < 0), (f * my) >> FRAC_BITS);
            res.en = sat48(eneg, e);
            res.hit = 1'b1;
        end
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [47:0] exp_v, logic [47:0] got_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    initial begin
        o_fail_count = 0;
        o_in_beats = 0;
        o_out_beats = 0;
        o_hit_beats = 0;
    end

    assign o_pending = force_q.size();

    always @(posedge i_clk) begin
        t_force_res want;
        if (!i_rst_n) begin
            box_l <= RST_BOX_LENGTH;
            inv_box <= RST_INV_BOX_LENGTH;
            cut_sq <= RST_CUT_RADIUS_SQ;
            min_sq <= RST_MIN_RADIUS_SQ;
            sig_sq <= RST_SIGMA_SQ;
            eps4 <= RST_FOUR_EPS;
            eps24 <= RST_TWENTYFOUR_EPS;
            f_lim <= RST_FORCE_LIMIT;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BOX_LENGTH:     box_l <= i_cfg_wdata;
                    CFG_INV_BOX_LENGTH: inv_box <= i_cfg_wdata;
                    CFG_CUT_RADIUS_SQ:  cut_sq <= i_cfg_wdata;
                    CFG_MIN_RADIUS_SQ:  min_sq <= i_cfg_wdata;
                    CFG_SIGMA_SQ:       sig_sq <= i_cfg_wdata;
                    CFG_FOUR_EPS:       eps4 <= i_cfg_wdata;
                    CFG_TWENTYFOUR_EPS: eps24 <= i_cfg_wdata;
                    CFG_FORCE_LIMIT:    f_lim <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                force_q.push_back(predict_force(i_delta_x, i_delta_y, i_first_tag, i_second_tag));
                o_in_beats++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_beats++;
                if (i_in_range) o_hit_beats++;
                if (force_q.size() == 0) begin
                    note_mismatch("unexpected beat", '0, '0);
                end else begin
                    want = force_q.pop_front();
                    if (i_force_x !== want.fx) note_mismatch("force_x", want.fx, i_force_x);
                    if (i_force_y !== want.fy) note_mismatch("force_y", want.fy, i_force_y);
                    if (i_energy_term !== want.en)
                        note_mismatch("energy_term", want.en, i_energy_term);
                    if (i_in_range !== want.hit) note_mismatch("in_range", want.hit, i_in_range);
                    if (i_first_tag_out !== want.t1)
                        note_mismatch("first_tag_out", want.t1, i_first_tag_out);
                    if (i_second_tag_out !== want.t2)
                        note_mismatch("second_tag_out", want.t2, i_second_tag_out);
                end
            end
        end
    end
endmodule

>>> tb/sv/lj_pair_force_2d_unit_tb.sv
// ---------------------------------------------------------------------------
// lj_pair_force_2d_unit_tb
// Drives pair beats under several register settings, mostly with random idling
// on both channels; the checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module lj_pair_force_2d_unit_tb;
    import lj2_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = 84;
    localparam int DOG_LIMIT  = 20000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [31:0]      i_delta_x = '0;
    logic signed [31:0]      i_delta_y = '0;
    logic [11:0]             i_first_tag = '0;
    logic [11:0]             i_second_tag = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [47:0]      o_force_x, o_force_y, o_energy_term;
    logic                    o_in_range;
    logic [11:0]             o_first_tag_out, o_second_tag_out;

    int fail_count, pending, in_beats, out_beats, hit_beats;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;

    always #6 i_clk = ~i_clk;

    lj_pair_force_2d_unit DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .o_in_stall, .i_delta_x, .i_delta_y, .i_first_tag, .i_second_tag,
        .o_out_valid, .i_out_stall, .o_force_x, .o_force_y, .o_energy_term,
        .o_in_range, .o_first_tag_out, .o_second_tag_out
    );

    lj_pair_force_2d_unit_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_delta_x, .i_delta_y,
        .i_first_tag, .i_second_tag,
        .i_out_valid(o_out_valid), .i_out_stall, .i_force_x(o_force_x),
        .i_force_y(o_force_y), .i_energy_term(o_energy_term), .i_in_range(o_in_range),
        .i_first_tag_out(o_first_tag_out), .i_second_tag_out(o_second_tag_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_in_beats(in_beats),
        .o_out_beats(out_beats), .o_hit_beats(hit_beats)
    );

    // receiver stall, redrawn every edge
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > DOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", DOG_LIMIT);
            $display("lj_pair_force_2d_unit_tb: done, errors");
            $finish;
        end
    end

    // one pair beat; valid stays up across back-to-back beats
    task automatic send_pair(logic signed [31:0] dx, logic signed [31:0] dy,
                             logic [11:0] t1, logic [11:0] t2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_delta_x <= dx;
        i_delta_y <= dy;
        i_first_tag <= t1;
        i_second_tag <= t2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT / 4) @(posedge i_clk);
    endtask

    // one write, then i_cfg_we low again before the task returns, so back-to-back writes never collide
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // pick a delta: mostly within +/- span, sometimes anything
    function automatic logic [31:0] pick_delta(int span);
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic random_pairs(int n, int span);
        repeat (n) send_pair(pick_delta(span), pick_delta(span), 12'($urandom()),
                             12'($urandom()));
    endtask

    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 66;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats under reset defaults
        send_pair(0, 0, 12'h000, 12'hFFF);                  // zero distance, floored
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 12'hFFF, 0); // field extremes
        send_pair(32'h0001_0000, 0, 12'hA5A, 12'h5A5);        // inside, under the floor
        send_pair(-32'sh0001_0000, 32'h0001_8000, 1, 2);
        send_pair(32'h0002_0000, 32'h0001_0000, 3, 4);       // inside, just above the floor
        send_pair(32'h0011_0000, 0, 5, 6);                   // exactly half box
        send_pair(32'h0022_0000 + 32'h0000_8000, 0, 7, 8);   // wraps to short image
        send_pair(-32'sh0021_C000, 32'sh0000_C000, 9, 10);
        send_pair(32'h0000_4000, 32'h0000_4000, 11, 12);     // deep core, force clamp
        send_pair(32'h0001_3000, 32'h0000_9000, 13, 14);     // under the floor, repulsive
        drain_results();

        // zero floor and zero sigma corner, unknown-box consistency off
        write_reg(CFG_MIN_RADIUS_SQ, 0);
        write_reg(CFG_SIGMA_SQ, 0);
        write_reg(CFG_INV_BOX_LENGTH, 32'hFFFF_FFFF);
        send_pair(0, 0, 15, 16);
        send_pair(32'h0000_0100, 0, 17, 18);
        send_pair(32'h4000_0000, -32'sh4000_0000, 19, 20);
        drain_results();

        // register extremes: all at max but inverse box and floor at zero
        write_reg(CFG_BOX_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_INV_BOX_LENGTH, 0);
        write_reg(CFG_CUT_RADIUS_SQ, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_RADIUS_SQ, 0);
        write_reg(CFG_SIGMA_SQ, 32'hFFFF_FFFF);
        write_reg(CFG_FOUR_EPS, 32'hFFFF_FFFF);
        write_reg(CFG_TWENTYFOUR_EPS, 32'hFFFF_FFFF);
        write_reg(CFG_FORCE_LIMIT, 32'hFFFF_FFFF);
        send_pair(0, 0, 21, 22);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 23, 24);
        random_pairs(80, 32'h0100_0000);
        drain_results();

        // all registers zero but sigma^2, which stays at max
        write_reg(CFG_BOX_LENGTH, 0);
        write_reg(CFG_CUT_RADIUS_SQ, 0);
        write_reg(CFG_FOUR_EPS, 0);
        write_reg(CFG_TWENTYFOUR_EPS, 0);
        write_reg(CFG_FORCE_LIMIT, 0);
        random_pairs(40, 32'h0001_0000);
        drain_results();

        // back to defaults, then sender idles lightly; swap idle mix
        write_reg(CFG_BOX_LENGTH, RST_BOX_LENGTH);
        write_reg(CFG_INV_BOX_LENGTH, RST_INV_BOX_LENGTH);
        write_reg(CFG_CUT_RADIUS_SQ, RST_CUT_RADIUS_SQ);
        write_reg(CFG_MIN_RADIUS_SQ, RST_MIN_RADIUS_SQ);
        write_reg(CFG_SIGMA_SQ, RST_SIGMA_SQ);
        write_reg(CFG_FOUR_EPS, RST_FOUR_EPS);
        write_reg(CFG_TWENTYFOUR_EPS, RST_TWENTYFOUR_EPS);
        write_reg(CFG_FORCE_LIMIT, RST_FORCE_LIMIT);
        random_pairs(300, 32'h0003_0000);
        send_idle_pct = 66;
        recv_idle_pct = 13;
        random_pairs(250, 32'h0003_0000);
        drain_results();

        // random potential settings on a fixed box, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BOX_LENGTH, 32'h0008_0000);
        write_reg(CFG_INV_BOX_LENGTH, 32'h2000_0000);
        write_reg(CFG_CUT_RADIUS_SQ, $urandom_range(32'h0010_0000, 32'h0001_0000));
        write_reg(CFG_MIN_RADIUS_SQ, $urandom_range(32'h0000_8000));
        write_reg(CFG_SIGMA_SQ, $urandom_range(32'h0002_0000, 32'h0000_4000));
        write_reg(CFG_FOUR_EPS, $urandom());
        write_reg(CFG_TWENTYFOUR_EPS, $urandom());
        write_reg(CFG_FORCE_LIMIT, $urandom());
        random_pairs(300, 32'h0006_0000);
        drain_results();

        repeat (PIPE_LAT * 2) @(posedge i_clk);
        $display("covered %0d pair beats, %0d results, %0d inside the cutoff",
                 in_beats, out_beats, hit_beats);
        $display("register sets: defaults, zero floor, all-max, all-zero, random");
        if (fail_count == 0 && pending == 0)
            $display("lj_pair_force_2d_unit_tb: done, clean");
        else
            $display("lj_pair_force_2d_unit_tb: done, errors");
        $finish;
    end
endmodule

>>> lj_pair_force_2d_unit.f
+incdir+rtl
rtl/lj2_pkg.sv
rtl/lj2_mul.sv
rtl/lj_pair_force_2d_unit.sv
rtl/lj2_chk.sv
tb/sv/lj_pair_force_2d_unit_chk.sv
tb/sv/lj_pair_force_2d_unit_tb.sv
